// ===== hdl/pcs_pkg.sv =====
// Shared types, constants and packet byte tables for the PTZ command scheduler.
// Used by pcs_front, pcs_fifo, pcs_back and ptz_camera_command_scheduler.
`timescale 1ns / 1ps

package pcs_pkg;

    localparam int FIFO_DEPTH = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_ADDRESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAN_PERIOD     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZOOM_PERIOD    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PACKET_ENABLES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LATENCY_LIMIT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF_LENGTH = 3'd5;

    // Enable bits
    localparam int EN_PT       = 0;
    localparam int EN_ZOOM_INQ = 1;
    localparam int EN_ZOOM_CMD = 2;
    localparam int EN_WATCHDOG = 3;

    // Packet kinds, also bit positions in the descriptor flags
    localparam logic [1:0] KIND_PT_INQ   = 2'd0;
    localparam logic [1:0] KIND_ZOOM_INQ = 2'd1;
    localparam logic [1:0] KIND_PT_CMD   = 2'd2;
    localparam logic [1:0] KIND_ZOOM_CMD = 2'd3;

    // Command bytes
    localparam logic [7:0] HDR_BASE    = 8'h80;
    localparam logic [7:0] B_INQUIRY   = 8'h09;
    localparam logic [7:0] B_COMMAND   = 8'h01;
    localparam logic [7:0] B_CAT_PT    = 8'h06;
    localparam logic [7:0] B_CAT_ZOOM  = 8'h04;
    localparam logic [7:0] B_PT_POS    = 8'h12;
    localparam logic [7:0] B_ZOOM_POS  = 8'h47;
    localparam logic [7:0] B_ABS_MOVE  = 8'h02;
    localparam logic [7:0] B_PAN_SPEED = 8'h18;
    localparam logic [7:0] B_TILT_SPD  = 8'h14;
    localparam logic [7:0] B_TERM      = 8'hFF;
    localparam logic [3:0] NIB_MASK    = 4'hF;

    typedef struct packed {
        logic [2:0]  camera_address;
        logic [15:0] pan_period;
        logic [15:0] zoom_period;
        logic [3:0]  packet_enables;
        logic [15:0] latency_limit;
        logic [7:0]  holdoff_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  hdr;
        logic [15:0] pan;
        logic [15:0] tilt;
        logic [15:0] zoom;
        logic [3:0]  flags;
    } desc_t;

    function automatic logic [7:0] nib(input logic [15:0] v, input logic [1:0] sel);
        logic [3:0] n;
        begin
            case (sel)
                2'd0: n = v[15:12];
                2'd1: n = v[11:8];
                2'd2: n = v[7:4];
                default: n = v[3:0];
            endcase
            return {4'h0, n & NIB_MASK};
        end
    endfunction

    // Index of the terminator byte of each packet kind
    function automatic logic [3:0] term_idx(input logic [1:0] kind);
        case (kind)
            KIND_PT_INQ:   return 4'd4;
            KIND_ZOOM_INQ: return 4'd4;
            KIND_PT_CMD:   return 4'd14;
            default:       return 4'd8;
        endcase
    endfunction

    function automatic logic [7:0] pkt_byte(input logic [1:0] kind, input logic [3:0] idx,
                                            input desc_t d);
        logic [7:0] b;
        begin
            b = B_TERM;
            case (kind)
                KIND_PT_INQ: begin
                    case (idx)
                        4'd0: b = d.hdr;
                        4'd1: b = B_INQUIRY;
                        4'd2: b = B_CAT_PT;
                        4'd3: b = B_PT_POS;
                        default: b = B_TERM;
                    endcase
                end
                KIND_ZOOM_INQ: begin
                    case (idx)
                        4'd0: b = d.hdr;
                        4'd1: b = B_INQUIRY;
                        4'd2: b = B_CAT_ZOOM;
                        4'd3: b = B_ZOOM_POS;
                        default: b = B_TERM;
                    endcase
                end
                KIND_PT_CMD: begin
                    case (idx)
                        4'd0: b = d.hdr;
                        4'd1: b = B_COMMAND;
                        4'd2: b = B_CAT_PT;
                        4'd3: b = B_ABS_MOVE;
                        4'd4: b = B_PAN_SPEED;
                        4'd5: b = B_TILT_SPD;
                        4'd6, 4'd7, 4'd8, 4'd9: b = nib(d.pan, 2'(idx - 4'd6));
                        4'd10, 4'd11, 4'd12, 4'd13: b = nib(d.tilt, 2'(idx - 4'd10));
                        default: b = B_TERM;
                    endcase
                end
                default: begin
                    case (idx)
                        4'd0: b = d.hdr;
                        4'd1: b = B_COMMAND;
                        4'd2: b = B_CAT_ZOOM;
                        4'd3: b = B_ZOOM_POS;
                        4'd4, 4'd5, 4'd6, 4'd7: b = nib(d.zoom, 2'(idx - 4'd4));
                        default: b = B_TERM;
                    endcase
                end
            endcase
            return b;
        end
    endfunction

endpackage

// ===== hdl/pcs_front.sv =====
// Front end: accepts iterations, keeps phase and holdoff state, builds packet descriptors.
// Depends on pcs_pkg.
`timescale 1ns / 1ps

module pcs_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pcs_pkg::cfg_t        cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_pan_units,
    input  logic signed [15:0]   s_tilt_units,
    input  logic [15:0]          s_zoom_position,
    input  logic [15:0]          s_zoom_send_latency,
    input  logic                 q_full,
    output logic                 q_push,
    output pcs_pkg::desc_t       q_data
);

    logic [15:0] pan_phase_reg, pan_phase_next;
    logic [15:0] zoom_phase_reg, zoom_phase_next;
    logic [7:0]  holdoff_reg, holdoff_next;
    logic [16:0] pan_sum, zoom_sum;
    logic        pan_wrap, zoom_wrap, accept;
    logic [3:0]  flags;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pan_sum   = {1'b0, pan_phase_reg} + 17'd1;
        zoom_sum  = {1'b0, zoom_phase_reg} + 17'd1;
        pan_wrap  = pan_sum >= {1'b0, cfg.pan_period};
        zoom_wrap = zoom_sum >= {1'b0, cfg.zoom_period};

        flags = '0;
        flags[pcs_pkg::KIND_PT_INQ]   = cfg.packet_enables[pcs_pkg::EN_PT] &&
                                        (pan_phase_reg == 16'd0);
        flags[pcs_pkg::KIND_ZOOM_INQ] = cfg.packet_enables[pcs_pkg::EN_ZOOM_INQ];
        flags[pcs_pkg::KIND_PT_CMD]   = cfg.packet_enables[pcs_pkg::EN_PT] && pan_wrap;
        flags[pcs_pkg::KIND_ZOOM_CMD] = cfg.packet_enables[pcs_pkg::EN_ZOOM_CMD] &&
                                        zoom_wrap && (holdoff_reg == 8'd0);

        q_data.hdr   = pcs_pkg::HDR_BASE | {5'd0, cfg.camera_address};
        q_data.pan   = s_pan_units;
        q_data.tilt  = s_tilt_units;
        q_data.zoom  = s_zoom_position;
        q_data.flags = flags;
        // drop iterations that emit nothing
        q_push = accept && (flags != 4'd0);

        pan_phase_next  = pan_wrap ? 16'd0 : pan_sum[15:0];
        zoom_phase_next = zoom_wrap ? 16'd0 : zoom_sum[15:0];
        if (flags[pcs_pkg::KIND_ZOOM_CMD] && cfg.packet_enables[pcs_pkg::EN_WATCHDOG] &&
            (s_zoom_send_latency > cfg.latency_limit)) begin
            holdoff_next = cfg.holdoff_length;
        end else if (holdoff_reg != 8'd0) begin
            holdoff_next = holdoff_reg - 8'd1;
        end else begin
            holdoff_next = holdoff_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_phase_reg  <= '0;
            zoom_phase_reg <= '0;
            holdoff_reg    <= '0;
        end else if (accept) begin
            pan_phase_reg  <= pan_phase_next;
            zoom_phase_reg <= zoom_phase_next;
            holdoff_reg    <= holdoff_next;
        end
    end

endmodule

// ===== hdl/pcs_fifo.sv =====
// Short descriptor queue between the front end and the byte serializer.
// Depends on pcs_pkg.
`timescale 1ns / 1ps

module pcs_fifo #(
    parameter int DEPTH = pcs_pkg::FIFO_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pcs_pkg::desc_t  wr_data,
    output logic            full,
    input  logic            pop,
    output logic            rd_valid,
    output pcs_pkg::desc_t  rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pcs_pkg::desc_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = count_reg == FULL_CNT;
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/pcs_back.sv =====
// Back end: walks the packets of the head descriptor, one byte per cycle;
// an output stall holds it. Depends on pcs_pkg.
`timescale 1ns / 1ps

module pcs_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  pcs_pkg::desc_t  q_data,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_tx_byte,
    output logic            m_packet_end,
    output logic            m_last
);

    logic [3:0] done_reg, done_next;
    logic [3:0] byte_reg, byte_next;
    logic       m_valid_reg;
    logic [7:0] tx_byte_reg;
    logic       packet_end_reg, last_reg;

    logic [3:0] pending, cur_mask;
    logic [1:0] kind;
    logic       advance, is_term, is_last;
    logic [7:0] cur_byte;

    always_comb begin
        pending  = q_data.flags & ~done_reg;
        cur_mask = pending & (~pending + 4'd1);
        case (cur_mask)
            4'b0010: kind = pcs_pkg::KIND_ZOOM_INQ;
            4'b0100: kind = pcs_pkg::KIND_PT_CMD;
            4'b1000: kind = pcs_pkg::KIND_ZOOM_CMD;
            default: kind = pcs_pkg::KIND_PT_INQ;
        endcase
        is_term  = byte_reg == pcs_pkg::term_idx(kind);
        is_last  = is_term && ((pending & ~cur_mask) == 4'd0);
        cur_byte = pcs_pkg::pkt_byte(kind, byte_reg, q_data);

        // output register empty or draining: take the next byte
        advance = q_valid && (!m_valid_reg || m_ready);
        q_pop   = advance && is_last;

        done_next = done_reg;
        byte_next = byte_reg;
        if (advance) begin
            if (is_last) begin
                done_next = '0;
                byte_next = '0;
            end else if (is_term) begin
                done_next = done_reg | cur_mask;
                byte_next = '0;
            end else begin
                byte_next = byte_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            byte_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
            byte_reg <= byte_next;
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tx_byte_reg    <= cur_byte;
            packet_end_reg <= is_term;
            last_reg       <= is_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_tx_byte    = tx_byte_reg;
    assign m_packet_end = packet_end_reg;
    assign m_last       = last_reg;

endmodule

// ===== hdl/ptz_camera_command_scheduler.sv =====
// Channel   | Direction | Handshake         | Payload
// s_        | in        | s_valid/s_ready   | pan_units, tilt_units, zoom_position, latency
// m_        | out       | m_valid/m_ready   | tx_byte, packet_end, last
// cfg_      | in        | cfg_wr_en         | cfg_index, cfg_wdata
//
// An iteration sends 5 to 34 bytes at the output, one byte per cycle unless stalled,
// from the byte serializer in pcs_back; iterations that enable no packet send none.
// The front end accepts a new iteration each cycle while the descriptor queue has room.
// Reset is synchronous and needs no clearing pass; the block accepts the cycle after.
// An output stall freezes the serializer; the front keeps going until the queue fills.
// Top level; depends on pcs_pkg, pcs_front, pcs_fifo and pcs_back.
`timescale 1ns / 1ps

module ptz_camera_command_scheduler #(
    parameter int FIFO_DEPTH = pcs_pkg::FIFO_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [15:0]             s_pan_units,
    input  logic signed [15:0]             s_tilt_units,
    input  logic [15:0]                    s_zoom_position,
    input  logic [15:0]                    s_zoom_send_latency,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_tx_byte,
    output logic                           m_packet_end,
    output logic                           m_last
);

    pcs_pkg::cfg_t  cfg_reg;
    pcs_pkg::desc_t push_data, head_data;
    logic           q_push, q_full, q_pop, q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.camera_address <= 3'd1;
            cfg_reg.pan_period     <= 16'd1;
            cfg_reg.zoom_period    <= 16'd1;
            cfg_reg.packet_enables <= 4'hF;
            cfg_reg.latency_limit  <= 16'd100;
            cfg_reg.holdoff_length <= 8'd10;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pcs_pkg::REG_CAMERA_ADDRESS: cfg_reg.camera_address <= cfg_wdata[2:0];
                pcs_pkg::REG_PAN_PERIOD:     cfg_reg.pan_period     <= cfg_wdata;
                pcs_pkg::REG_ZOOM_PERIOD:    cfg_reg.zoom_period    <= cfg_wdata;
                pcs_pkg::REG_PACKET_ENABLES: cfg_reg.packet_enables <= cfg_wdata[3:0];
                pcs_pkg::REG_LATENCY_LIMIT:  cfg_reg.latency_limit  <= cfg_wdata;
                pcs_pkg::REG_HOLDOFF_LENGTH: cfg_reg.holdoff_length <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    pcs_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_pan_units         (s_pan_units),
        .s_tilt_units        (s_tilt_units),
        .s_zoom_position     (s_zoom_position),
        .s_zoom_send_latency (s_zoom_send_latency),
        .q_full              (q_full),
        .q_push              (q_push),
        .q_data              (push_data)
    );

    pcs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_data  (push_data),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (head_data)
    );

    pcs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_data       (head_data),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tx_byte    (m_tx_byte),
        .m_packet_end (m_packet_end),
        .m_last       (m_last)
    );

endmodule

// ===== hdl/pcs_checker.sv =====
// Port-level checks on the byte stream of ptz_camera_command_scheduler.
// Bound to the top level; depends on nothing else.
`timescale 1ns / 1ps

module pcs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_tx_byte,
    input logic       m_packet_end,
    input logic       m_last
);

    localparam logic [7:0] TERM_BYTE = 8'hFF;

    // stalled transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) &&
                                $stable(m_packet_end) && $stable(m_last))
        else $error("output transaction changed while stalled");

    a_term_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_packet_end |-> m_tx_byte == TERM_BYTE)
        else $error("packet end flagged on a byte other than the terminator");

    a_last_ends_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_packet_end)
        else $error("last byte of an iteration is not a packet terminator");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind ptz_camera_command_scheduler pcs_checker u_pcs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_tx_byte    (m_tx_byte),
    .m_packet_end (m_packet_end),
    .m_last       (m_last)
);
